[rtl/core/psce_pkg.sv]
// ----------------------------------------------------------------------------
// psce_pkg
// Shared constants and types for the Pauli-string connection engine.
// ----------------------------------------------------------------------------
package psce_pkg;

    localparam int PSCE_QUBITS = 64;
    localparam int PSCE_TERMS  = 64;
    localparam int PSCE_GROUPS = 32;

    localparam int WORD_W   = 64;
    localparam int WEIGHT_W = 24;
    localparam int ELEM_W   = 30;
    localparam int CUTOFF_W = 62;
    localparam int SQ_W     = 2 * ELEM_W;

    localparam logic [1:0] CMD_LOAD   = 2'd0;
    localparam logic [1:0] CMD_EVAL   = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam logic [1:0] KIND_ACK  = 2'd0;
    localparam logic [1:0] KIND_CONN = 2'd1;
    localparam logic [1:0] KIND_END  = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_L_RD,
        ST_L_CMP,
        ST_L_WR,
        ST_CLR,
        ST_E_TERM,
        ST_E_DRAIN,
        ST_G_RD,
        ST_G_SAT,
        ST_G_MUL,
        ST_G_CMP,
        ST_E_END
    } state_t;

endpackage

[rtl/core/pauli_string_connection_engine.sv]
// ----------------------------------------------------------------------------
// pauli_string_connection_engine
// Stores Pauli-string terms grouped by flip mask and lists the row elements
// of the operator for a basis configuration above the squared-magnitude cutoff.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) takes one command per transfer: load a
//   term, evaluate a configuration, or clear the table. Output channel
//   (out_valid/out_ready) returns one acknowledge for load and clear, and for
//   evaluate one connection per surviving group followed by an end item.
//   last is high on the final result of each command. cfg_we writes the
//   squared-magnitude cutoff; write it only while the block is idle.
// Operation:
//   Load walks the group flip memory, reading and comparing each stored
//   group until the flip mask matches or the groups run out, then writes the
//   term. Evaluate streams the term memory at one term per cycle into the
//   group accumulator memory (read-modify-write with forwarding), drains
//   the pipeline, then reads, saturates, squares and compares each group.
//   Clear empties both tables. One command is processed at a time.
// Reset and stall:
//   Reset empties both tables and sets the cutoff to zero. A result waits in
//   the output register while out_ready is low; the block holds the next
//   result until that transfer, and takes a new command once it is idle.
// ----------------------------------------------------------------------------
module pauli_string_connection_engine
    import psce_pkg::*;
#(
    parameter int QUBITS = PSCE_QUBITS,
    parameter int TERMS  = PSCE_TERMS,
    parameter int GROUPS = PSCE_GROUPS
)(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [CUTOFF_W-1:0]        cfg_wdata,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [1:0]                 command,
    input  logic [WORD_W-1:0]          x_mask,
    input  logic [WORD_W-1:0]          z_mask,
    input  logic signed [WEIGHT_W-1:0] weight_re,
    input  logic signed [WEIGHT_W-1:0] weight_im,
    input  logic [WORD_W-1:0]          configuration,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [1:0]                 kind,
    output logic                       status,
    output logic [WORD_W-1:0]          flip_mask,
    output logic [WORD_W-1:0]          new_configuration,
    output logic signed [ELEM_W-1:0]   element_re,
    output logic signed [ELEM_W-1:0]   element_im,
    output logic                       last
);

    localparam int TW    = (TERMS > 1) ? $clog2(TERMS) : 1;
    localparam int TCW   = $clog2(TERMS + 1);
    localparam int GW    = (GROUPS > 1) ? $clog2(GROUPS) : 1;
    localparam int GCW   = $clog2(GROUPS + 1);
    localparam int ACC_W = WEIGHT_W + 1 + TW;

    function automatic logic signed [WEIGHT_W-1:0] neg_sat(
        input logic signed [WEIGHT_W-1:0] v);
        logic signed [WEIGHT_W-1:0] r;
        r = (v == {1'b1, {(WEIGHT_W-1){1'b0}}}) ? {1'b0, {(WEIGHT_W-1){1'b1}}} : -v;
        return r;
    endfunction

    function automatic logic signed [ELEM_W-1:0] sat_elem(
        input logic signed [ACC_W-1:0] v);
        logic signed [63:0] x;
        logic signed [ELEM_W-1:0] r;
        x = 64'(v);
        if (x > 64'sd536870911)
            r = {1'b0, {(ELEM_W-1){1'b1}}};
        else if (x < -64'sd536870912)
            r = {1'b1, {(ELEM_W-1){1'b0}}};
        else
            r = ELEM_W'(x);
        return r;
    endfunction

    // ---------------- registers ----------------
    state_t                      state_reg, state_next;
    logic [TCW-1:0]              term_cnt_reg, term_cnt_next;
    logic [GCW-1:0]              group_cnt_reg, group_cnt_next;
    logic [CUTOFF_W-1:0]         cutoff_reg;
    logic [TCW-1:0]              t_idx_reg, t_idx_next;
    logic [GCW-1:0]              g_idx_reg, g_idx_next;
    logic [GCW-1:0]              found_reg, found_next;
    logic [GROUPS-1:0]           gvalid_reg, gvalid_next;
    logic                        s1_vld_reg, s1_vld_next;
    logic                        s2_vld_reg, s2_vld_next;
    logic                        wr_vld_reg, wr_vld_next;
    logic                        out_valid_reg, out_valid_next;

    logic [QUBITS-1:0]           xm_reg, xm_next;
    logic [QUBITS-1:0]           zm_reg, zm_next;
    logic [QUBITS-1:0]           conf_reg, conf_next;
    logic signed [WEIGHT_W-1:0]  wre_reg, wre_next;
    logic signed [WEIGHT_W-1:0]  wim_reg, wim_next;
    logic [GW-1:0]               s2_grp_reg, s2_grp_next;
    logic signed [ACC_W-1:0]     s2_dre_reg, s2_dre_next;
    logic signed [ACC_W-1:0]     s2_dim_reg, s2_dim_next;
    logic [GW-1:0]               wr_grp_reg, wr_grp_next;
    logic signed [ACC_W-1:0]     wr_re_reg, wr_re_next;
    logic signed [ACC_W-1:0]     wr_im_reg, wr_im_next;
    logic signed [ELEM_W-1:0]    sre_reg, sre_next;
    logic signed [ELEM_W-1:0]    sim_reg, sim_next;
    logic [QUBITS-1:0]           flip_reg, flip_next;
    logic [SQ_W-1:0]             mre_reg, mre_next;
    logic [SQ_W-1:0]             mim_reg, mim_next;

    logic [1:0]                  kind_reg, kind_next;
    logic                        status_reg, status_next;
    logic [QUBITS-1:0]           flip_out_reg, flip_out_next;
    logic [QUBITS-1:0]           nconf_reg, nconf_next;
    logic signed [ELEM_W-1:0]    ere_reg, ere_next;
    logic signed [ELEM_W-1:0]    eim_reg, eim_next;
    logic                        last_reg, last_next;

    // ---------------- memories ----------------
    logic [QUBITS-1:0]           term_zm_mem  [TERMS];
    logic signed [WEIGHT_W-1:0]  term_wre_mem [TERMS];
    logic signed [WEIGHT_W-1:0]  term_wim_mem [TERMS];
    logic [GW-1:0]               term_grp_mem [TERMS];
    logic [QUBITS-1:0]           gflip_mem    [GROUPS];
    logic [2*ACC_W-1:0]          acc_mem      [GROUPS];

    logic [QUBITS-1:0]           term_zm_rd;
    logic signed [WEIGHT_W-1:0]  term_wre_rd;
    logic signed [WEIGHT_W-1:0]  term_wim_rd;
    logic [GW-1:0]               term_grp_rd;
    logic [QUBITS-1:0]           gflip_rd;
    logic [2*ACC_W-1:0]          acc_rd;

    logic                        term_we;
    logic                        gflip_we;
    logic                        acc_we;
    logic [GW-1:0]               acc_raddr;
    logic [2*ACC_W-1:0]          acc_wdata;

    // ---------------- combinational ----------------
    logic                        out_free;
    logic [1:0]                  rot;
    logic                        parity;
    logic signed [ACC_W-1:0]     dre, dim;
    logic signed [ACC_W-1:0]     old_re, old_im;
    logic signed [ACC_W-1:0]     sum_re, sum_im;
    logic [2*ACC_W-1:0]          grp_acc;
    logic [SQ_W:0]               mag;
    logic                        refuse;

    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == ST_IDLE);
    assign rot      = 2'($countones(x_mask[QUBITS-1:0] & z_mask[QUBITS-1:0]));
    assign parity   = ^(conf_reg & term_zm_rd);
    assign dre      = ACC_W'(term_wre_rd);
    assign dim      = ACC_W'(term_wim_rd);
    assign acc_raddr = (state_reg == ST_G_RD) ? g_idx_reg[GW-1:0] : term_grp_rd;
    assign mag      = {1'b0, mre_reg} + {1'b0, mim_reg};
    assign refuse   = (term_cnt_reg >= TCW'(TERMS)) ||
                      ((found_reg == group_cnt_reg) && (group_cnt_reg >= GCW'(GROUPS)));

    // accumulator read-modify-write; forward the write of the previous cycle
    always_comb
    begin
        if (wr_vld_reg && (wr_grp_reg == s2_grp_reg))
        begin
            old_re = wr_re_reg;
            old_im = wr_im_reg;
        end
        else if (gvalid_reg[s2_grp_reg])
        begin
            old_re = acc_rd[2*ACC_W-1:ACC_W];
            old_im = acc_rd[ACC_W-1:0];
        end
        else
        begin
            old_re = '0;
            old_im = '0;
        end
        sum_re    = old_re + s2_dre_reg;
        sum_im    = old_im + s2_dim_reg;
        acc_wdata = {sum_re, sum_im};
        grp_acc   = gvalid_reg[g_idx_reg[GW-1:0]] ? acc_rd : '0;
    end

    always_comb
    begin
        state_next     = state_reg;
        term_cnt_next  = term_cnt_reg;
        group_cnt_next = group_cnt_reg;
        t_idx_next     = t_idx_reg;
        g_idx_next     = g_idx_reg;
        found_next     = found_reg;
        gvalid_next    = gvalid_reg;
        out_valid_next = out_valid_reg && !out_ready;
        xm_next        = xm_reg;
        zm_next        = zm_reg;
        conf_next      = conf_reg;
        wre_next       = wre_reg;
        wim_next       = wim_reg;
        sre_next       = sre_reg;
        sim_next       = sim_reg;
        flip_next      = flip_reg;
        mre_next       = mre_reg;
        mim_next       = mim_reg;
        kind_next      = kind_reg;
        status_next    = status_reg;
        flip_out_next  = flip_out_reg;
        nconf_next     = nconf_reg;
        ere_next       = ere_reg;
        eim_next       = eim_reg;
        last_next      = last_reg;
        term_we        = 1'b0;
        gflip_we       = 1'b0;
        s1_vld_next    = 1'b0;

        // accumulate pipeline runs on its own once terms are issued
        s2_vld_next = s1_vld_reg;
        s2_grp_next = term_grp_rd;
        s2_dre_next = parity ? -dre : dre;
        s2_dim_next = parity ? -dim : dim;
        acc_we      = s2_vld_reg;
        wr_vld_next = s2_vld_reg;
        wr_grp_next = s2_grp_reg;
        wr_re_next  = sum_re;
        wr_im_next  = sum_im;
        if (s2_vld_reg)
            gvalid_next[s2_grp_reg] = 1'b1;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    case (command)
                        CMD_LOAD:
                        begin
                            xm_next    = x_mask[QUBITS-1:0];
                            zm_next    = z_mask[QUBITS-1:0];
                            case (rot)
                                2'd1:
                                begin
                                    wre_next = neg_sat(weight_im);
                                    wim_next = weight_re;
                                end
                                2'd2:
                                begin
                                    wre_next = neg_sat(weight_re);
                                    wim_next = neg_sat(weight_im);
                                end
                                2'd3:
                                begin
                                    wre_next = weight_im;
                                    wim_next = neg_sat(weight_re);
                                end
                                default:
                                begin
                                    wre_next = weight_re;
                                    wim_next = weight_im;
                                end
                            endcase
                            g_idx_next = '0;
                            state_next = ST_L_RD;
                        end
                        CMD_EVAL:
                        begin
                            conf_next   = configuration[QUBITS-1:0];
                            t_idx_next  = '0;
                            gvalid_next = '0;
                            wr_vld_next = 1'b0;
                            state_next  = ST_E_TERM;
                        end
                        default:
                            state_next = ST_CLR;
                    endcase
                end
            end
            ST_L_RD:
            begin
                if (g_idx_reg == group_cnt_reg)
                begin
                    found_next = g_idx_reg;
                    state_next = ST_L_WR;
                end
                else
                    state_next = ST_L_CMP;
            end
            ST_L_CMP:
            begin
                if (gflip_rd == xm_reg)
                begin
                    found_next = g_idx_reg;
                    state_next = ST_L_WR;
                end
                else
                begin
                    g_idx_next = g_idx_reg + 1'b1;
                    state_next = ST_L_RD;
                end
            end
            ST_L_WR:
            begin
                if (out_free)
                begin
                    if (!refuse)
                    begin
                        term_we       = 1'b1;
                        term_cnt_next = term_cnt_reg + 1'b1;
                        if (found_reg == group_cnt_reg)
                        begin
                            gflip_we       = 1'b1;
                            group_cnt_next = group_cnt_reg + 1'b1;
                        end
                    end
                    out_valid_next = 1'b1;
                    kind_next      = KIND_ACK;
                    status_next    = refuse;
                    flip_out_next  = '0;
                    nconf_next     = '0;
                    ere_next       = '0;
                    eim_next       = '0;
                    last_next      = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_CLR:
            begin
                if (out_free)
                begin
                    term_cnt_next  = '0;
                    group_cnt_next = '0;
                    out_valid_next = 1'b1;
                    kind_next      = KIND_ACK;
                    status_next    = 1'b0;
                    flip_out_next  = '0;
                    nconf_next     = '0;
                    ere_next       = '0;
                    eim_next       = '0;
                    last_next      = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_E_TERM:
            begin
                if (t_idx_reg < term_cnt_reg)
                begin
                    s1_vld_next = 1'b1;
                    t_idx_next  = t_idx_reg + 1'b1;
                end
                else
                    state_next = ST_E_DRAIN;
            end
            ST_E_DRAIN:
            begin
                if (!s1_vld_reg && !s2_vld_reg)
                begin
                    g_idx_next = '0;
                    state_next = ST_G_RD;
                end
            end
            ST_G_RD:
            begin
                if (g_idx_reg == group_cnt_reg)
                    state_next = ST_E_END;
                else
                    state_next = ST_G_SAT;
            end
            ST_G_SAT:
            begin
                sre_next   = sat_elem(grp_acc[2*ACC_W-1:ACC_W]);
                sim_next   = sat_elem(grp_acc[ACC_W-1:0]);
                flip_next  = gflip_rd;
                state_next = ST_G_MUL;
            end
            ST_G_MUL:
            begin
                mre_next   = SQ_W'(sre_reg * sre_reg);
                mim_next   = SQ_W'(sim_reg * sim_reg);
                state_next = ST_G_CMP;
            end
            ST_G_CMP:
            begin
                if (CUTOFF_W'(mag) > cutoff_reg)
                begin
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        kind_next      = KIND_CONN;
                        status_next    = 1'b0;
                        flip_out_next  = flip_reg;
                        nconf_next     = conf_reg ^ flip_reg;
                        ere_next       = sre_reg;
                        eim_next       = sim_reg;
                        last_next      = 1'b0;
                        g_idx_next     = g_idx_reg + 1'b1;
                        state_next     = ST_G_RD;
                    end
                end
                else
                begin
                    g_idx_next = g_idx_reg + 1'b1;
                    state_next = ST_G_RD;
                end
            end
            ST_E_END:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = KIND_END;
                    status_next    = 1'b0;
                    flip_out_next  = '0;
                    nconf_next     = '0;
                    ere_next       = '0;
                    eim_next       = '0;
                    last_next      = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // ---------------- memory ports ----------------
    always_ff @(posedge clk)
    begin
        if (term_we)
        begin
            term_zm_mem[term_cnt_reg[TW-1:0]]  <= zm_reg;
            term_wre_mem[term_cnt_reg[TW-1:0]] <= wre_reg;
            term_wim_mem[term_cnt_reg[TW-1:0]] <= wim_reg;
            term_grp_mem[term_cnt_reg[TW-1:0]] <= found_reg[GW-1:0];
        end
        term_zm_rd  <= term_zm_mem[t_idx_reg[TW-1:0]];
        term_wre_rd <= term_wre_mem[t_idx_reg[TW-1:0]];
        term_wim_rd <= term_wim_mem[t_idx_reg[TW-1:0]];
        term_grp_rd <= term_grp_mem[t_idx_reg[TW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (gflip_we)
            gflip_mem[found_reg[GW-1:0]] <= xm_reg;
        gflip_rd <= gflip_mem[g_idx_reg[GW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (acc_we)
            acc_mem[s2_grp_reg] <= acc_wdata;
        acc_rd <= acc_mem[acc_raddr];
    end

    // ---------------- control registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            term_cnt_reg  <= '0;
            group_cnt_reg <= '0;
            cutoff_reg    <= '0;
            t_idx_reg     <= '0;
            g_idx_reg     <= '0;
            found_reg     <= '0;
            gvalid_reg    <= '0;
            s1_vld_reg    <= 1'b0;
            s2_vld_reg    <= 1'b0;
            wr_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            term_cnt_reg  <= term_cnt_next;
            group_cnt_reg <= group_cnt_next;
            if (cfg_we)
                cutoff_reg <= cfg_wdata;
            t_idx_reg     <= t_idx_next;
            g_idx_reg     <= g_idx_next;
            found_reg     <= found_next;
            gvalid_reg    <= gvalid_next;
            s1_vld_reg    <= s1_vld_next;
            s2_vld_reg    <= s2_vld_next;
            wr_vld_reg    <= wr_vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge clk)
    begin
        xm_reg       <= xm_next;
        zm_reg       <= zm_next;
        conf_reg     <= conf_next;
        wre_reg      <= wre_next;
        wim_reg      <= wim_next;
        s2_grp_reg   <= s2_grp_next;
        s2_dre_reg   <= s2_dre_next;
        s2_dim_reg   <= s2_dim_next;
        wr_grp_reg   <= wr_grp_next;
        wr_re_reg    <= wr_re_next;
        wr_im_reg    <= wr_im_next;
        sre_reg      <= sre_next;
        sim_reg      <= sim_next;
        flip_reg     <= flip_next;
        mre_reg      <= mre_next;
        mim_reg      <= mim_next;
        kind_reg     <= kind_next;
        status_reg   <= status_next;
        flip_out_reg <= flip_out_next;
        nconf_reg    <= nconf_next;
        ere_reg      <= ere_next;
        eim_reg      <= eim_next;
        last_reg     <= last_next;
    end

    assign out_valid         = out_valid_reg;
    assign kind              = kind_reg;
    assign status            = status_reg;
    assign flip_mask         = WORD_W'(flip_out_reg);
    assign new_configuration = WORD_W'(nconf_reg);
    assign element_re        = ere_reg;
    assign element_im        = eim_reg;
    assign last              = last_reg;

`ifndef SYNTHESIS
    a_term_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        term_cnt_reg <= TCW'(TERMS))
        else $error("term count beyond table depth");

    a_group_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        (group_cnt_reg <= GCW'(GROUPS)) && (TCW'(group_cnt_reg) <= term_cnt_reg))
        else $error("group count inconsistent with term count");

    a_idle_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (!s1_vld_reg && !s2_vld_reg))
        else $error("accumulate pipeline busy while idle");

    a_square_after_sat: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_G_MUL) |-> ($past(state_reg) == ST_G_SAT))
        else $error("square stage entered without saturated sums");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> (out_valid_reg && $stable(kind_reg)))
        else $error("pending result dropped or changed");
`endif

endmodule
